[hw/rtl/tsdc_pkg.sv]
`timescale 1ns / 1ps

package tsdc_pkg;

    localparam int SQUARE_SIDE = 5;
    localparam int CELLS       = SQUARE_SIDE * SQUARE_SIDE;
    localparam int LETTER_W    = 5;
    localparam int POS_W       = $clog2(SQUARE_SIDE);
    localparam int CELL_W      = $clog2(CELLS);
    localparam int CFG_W       = 45;
    localparam int CFG_IDX_W   = 3;
    localparam int NUM_LOOKUPS = 4;

    localparam int WORD0_BASE = 0;
    localparam int WORD0_CNT  = 9;
    localparam int WORD1_BASE = 9;
    localparam int WORD1_CNT  = 8;
    localparam int WORD2_BASE = 17;
    localparam int WORD2_CNT  = 8;

    localparam logic [LETTER_W-1:0] CODE_I = 5'd8;
    localparam logic [LETTER_W-1:0] CODE_J = 5'd9;
    localparam logic [LETTER_W-1:0] CODE_X = 5'd23;

    localparam logic CMD_ENCRYPT = 1'b0;
    localparam logic CMD_DECRYPT = 1'b1;

    // Lookup slots: which letter is searched in which square.
    localparam int LK_1A = 0;
    localparam int LK_1B = 1;
    localparam int LK_2A = 2;
    localparam int LK_2B = 3;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_A0,
        REG_A1,
        REG_A2,
        REG_B0,
        REG_B1,
        REG_B2
    } t_cfg_reg;

    typedef logic [LETTER_W-1:0] t_letter;
    typedef t_letter [CELLS-1:0] t_square;

    typedef struct packed {
        logic             found;
        logic [POS_W-1:0] row;
        logic [POS_W-1:0] col;
    } t_place;

    typedef struct packed {
        logic                                cmd;
        t_letter                             l1;
        t_letter                             l2;
        logic [NUM_LOOKUPS-1:0][CELLS-1:0]   hit;
    } t_match;

    typedef struct packed {
        logic                                             cmd;
        t_letter                                          l1;
        t_letter                                          l2;
        logic [NUM_LOOKUPS-1:0][SQUARE_SIDE-1:0]          row_hit;
        logic [NUM_LOOKUPS-1:0][SQUARE_SIDE-1:0][POS_W-1:0] row_col;
    } t_rows;

    typedef struct packed {
        logic                      cmd;
        t_letter                   l1;
        t_letter                   l2;
        t_place [NUM_LOOKUPS-1:0]  place;
    } t_found;

    typedef struct packed {
        t_letter first;
        t_letter second;
        logic    missing;
    } t_result;

endpackage

[hw/rtl/tsdc_match.sv]
`timescale 1ns / 1ps

module tsdc_match import tsdc_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_valid,
    output logic    o_ready,
    input  logic    i_cmd,
    input  t_letter i_l1,
    input  t_letter i_l2,
    input  logic    i_present,
    input  t_square i_sq_a,
    input  t_square i_sq_b,
    output logic    o_valid,
    input  logic    i_ready,
    output t_match  o_data
);

    logic   r_valid;
    t_match r_data;
    t_match n_data;

    function automatic logic [CELLS-1:0] hit_vec(input t_letter letter, input t_square sq);
        logic [CELLS-1:0] v;
        for (int k = 0; k < CELLS; k++) begin
            v[k] = (sq[k] == letter) || ((letter == CODE_J) && (sq[k] == CODE_I));
        end
        return v;
    endfunction

    always_comb begin
        n_data.cmd = i_cmd;
        n_data.l1  = i_l1;
        n_data.l2  = ((i_cmd == CMD_ENCRYPT) && !i_present) ? CODE_X : i_l2;
        n_data.hit[LK_1A] = hit_vec(n_data.l1, i_sq_a);
        n_data.hit[LK_1B] = hit_vec(n_data.l1, i_sq_b);
        n_data.hit[LK_2A] = hit_vec(n_data.l2, i_sq_a);
        n_data.hit[LK_2B] = hit_vec(n_data.l2, i_sq_b);
    end

    assign o_ready = !r_valid || i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_data <= n_data;
        end
    end

    assign o_valid = r_valid;
    assign o_data  = r_data;

endmodule

[hw/rtl/tsdc_locate.sv]
`timescale 1ns / 1ps

module tsdc_locate import tsdc_pkg::*; (
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  logic   i_valid,
    output logic   o_ready,
    input  t_match i_data,
    output logic   o_valid,
    input  logic   i_ready,
    output t_found o_data
);

    logic   r_valid_rows;
    t_rows  r_rows;
    t_rows  n_rows;
    logic   r_valid_found;
    t_found r_found;
    t_found n_found;
    logic   rows_ready;

    // Within each row the highest matching column wins.
    always_comb begin
        logic [SQUARE_SIDE-1:0] slice;
        n_rows.cmd = i_data.cmd;
        n_rows.l1  = i_data.l1;
        n_rows.l2  = i_data.l2;
        for (int lk = 0; lk < NUM_LOOKUPS; lk++) begin
            for (int r = 0; r < SQUARE_SIDE; r++) begin
                slice = i_data.hit[lk][r*SQUARE_SIDE +: SQUARE_SIDE];
                n_rows.row_hit[lk][r] = |slice;
                n_rows.row_col[lk][r] = '0;
                for (int c = 0; c < SQUARE_SIDE; c++) begin
                    if (slice[c]) begin
                        n_rows.row_col[lk][r] = POS_W'(c);
                    end
                end
            end
        end
    end

    // The highest matching row wins.
    always_comb begin
        n_found.cmd = r_rows.cmd;
        n_found.l1  = r_rows.l1;
        n_found.l2  = r_rows.l2;
        for (int lk = 0; lk < NUM_LOOKUPS; lk++) begin
            n_found.place[lk] = '0;
            for (int r = 0; r < SQUARE_SIDE; r++) begin
                if (r_rows.row_hit[lk][r]) begin
                    n_found.place[lk].found = 1'b1;
                    n_found.place[lk].row   = POS_W'(r);
                    n_found.place[lk].col   = r_rows.row_col[lk][r];
                end
            end
        end
    end

    assign rows_ready = !r_valid_found || i_ready;
    assign o_ready    = !r_valid_rows || rows_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid_rows  <= 1'b0;
            r_valid_found <= 1'b0;
        end else begin
            if (o_ready) begin
                r_valid_rows <= i_valid;
            end
            if (rows_ready) begin
                r_valid_found <= r_valid_rows;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_rows <= n_rows;
        end
        if (rows_ready && r_valid_rows) begin
            r_found <= n_found;
        end
    end

    assign o_valid = r_valid_found;
    assign o_data  = r_found;

endmodule

[hw/rtl/tsdc_select.sv]
`timescale 1ns / 1ps

module tsdc_select import tsdc_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_valid,
    output logic    o_ready,
    input  t_found  i_data,
    input  t_square i_sq_a,
    input  t_square i_sq_b,
    output logic    o_valid,
    input  logic    i_ready,
    output t_result o_data
);

    logic    r_valid;
    t_result r_data;
    t_result n_data;

    function automatic logic [CELL_W-1:0] cell_idx(input logic [POS_W-1:0] row,
                                                  input logic [POS_W-1:0] col);
        return CELL_W'(row) * CELL_W'(SQUARE_SIDE) + CELL_W'(col);
    endfunction

    always_comb begin
        t_place t1;
        t_place t2;
        t_place p1;
        t_place p2;
        if (i_data.cmd == CMD_DECRYPT) begin
            t1 = i_data.place[LK_1B];
            t2 = i_data.place[LK_2A];
        end else begin
            t1 = i_data.place[LK_1A];
            t2 = i_data.place[LK_2B];
        end
        p1 = i_data.place[LK_1A];
        p2 = i_data.place[LK_2B];

        n_data.first   = i_data.l2;
        n_data.second  = i_data.l1;
        n_data.missing = 1'b0;
        if (!(t1.found && t2.found)) begin
            n_data.missing = 1'b1;
        end else if (t1.col == t2.col) begin
            n_data.missing = 1'b0;
        end else if (!(p1.found && p2.found)) begin
            n_data.missing = 1'b1;
        end else begin
            n_data.first  = i_sq_a[cell_idx(p1.row, p2.col)];
            n_data.second = i_sq_b[cell_idx(p2.row, p1.col)];
        end
    end

    assign o_ready = !r_valid || i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_data <= n_data;
        end
    end

    assign o_valid = r_valid;
    assign o_data  = r_data;

endmodule

[hw/rtl/two_square_digraph_cipher.sv]
`timescale 1ns / 1ps

// Two-square digraph cipher, one letter pair per item.
// The input channel (i_in_valid, o_in_ready) takes a command, two letter codes
// and a flag telling whether the second letter is present. The output channel
// (o_out_valid, i_out_ready) gives the result pair and a missing-letter flag.
// Both squares are loaded through the write port i_cfg_we, i_cfg_index and
// i_cfg_wdata, three words per square. The user must load them only while no
// item is in flight; the block itself does not enforce this. The pipeline has four
// register stages: letter compare, row scan, row pick, and result select
// into the output register. It accepts a new item every cycle unless stalled.
// Each stage has its own valid bit and takes a new item whenever it is empty
// or its contents move on, so bubbles close up while the receiver stalls and
// the block keeps accepting items until all four stages are full.
// Reset empties the pipeline and clears both squares to zero.

module two_square_digraph_cipher import tsdc_pkg::*; (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_ready,
    input  logic                 i_command,
    input  logic [4:0]           i_first_letter,
    input  logic [4:0]           i_second_letter,
    input  logic                 i_second_present,
    output logic                 o_out_valid,
    input  logic                 i_out_ready,
    output logic [4:0]           o_out_first,
    output logic [4:0]           o_out_second,
    output logic                 o_letter_missing,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [CFG_W-1:0]     i_cfg_wdata
);

    t_square r_sq_a;
    t_square r_sq_b;

    logic    match_valid;
    logic    match_ready;
    t_match  match_data;
    logic    found_valid;
    logic    found_ready;
    t_found  found_data;
    t_result result;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sq_a <= '0;
            r_sq_b <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                REG_A0: begin
                    for (int k = 0; k < WORD0_CNT; k++) begin
                        r_sq_a[WORD0_BASE + k] <= i_cfg_wdata[LETTER_W*k +: LETTER_W];
                    end
                end
                REG_A1: begin
                    for (int k = 0; k < WORD1_CNT; k++) begin
                        r_sq_a[WORD1_BASE + k] <= i_cfg_wdata[LETTER_W*k +: LETTER_W];
                    end
                end
                REG_A2: begin
                    for (int k = 0; k < WORD2_CNT; k++) begin
                        r_sq_a[WORD2_BASE + k] <= i_cfg_wdata[LETTER_W*k +: LETTER_W];
                    end
                end
                REG_B0: begin
                    for (int k = 0; k < WORD0_CNT; k++) begin
                        r_sq_b[WORD0_BASE + k] <= i_cfg_wdata[LETTER_W*k +: LETTER_W];
                    end
                end
                REG_B1: begin
                    for (int k = 0; k < WORD1_CNT; k++) begin
                        r_sq_b[WORD1_BASE + k] <= i_cfg_wdata[LETTER_W*k +: LETTER_W];
                    end
                end
                REG_B2: begin
                    for (int k = 0; k < WORD2_CNT; k++) begin
                        r_sq_b[WORD2_BASE + k] <= i_cfg_wdata[LETTER_W*k +: LETTER_W];
                    end
                end
                default: begin
                end
            endcase
        end
    end

    tsdc_match u_match (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (i_in_valid),
        .o_ready   (o_in_ready),
        .i_cmd     (i_command),
        .i_l1      (i_first_letter),
        .i_l2      (i_second_letter),
        .i_present (i_second_present),
        .i_sq_a    (r_sq_a),
        .i_sq_b    (r_sq_b),
        .o_valid   (match_valid),
        .i_ready   (match_ready),
        .o_data    (match_data)
    );

    tsdc_locate u_locate (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (match_valid),
        .o_ready (match_ready),
        .i_data  (match_data),
        .o_valid (found_valid),
        .i_ready (found_ready),
        .o_data  (found_data)
    );

    tsdc_select u_select (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (found_valid),
        .o_ready (found_ready),
        .i_data  (found_data),
        .i_sq_a  (r_sq_a),
        .i_sq_b  (r_sq_b),
        .o_valid (o_out_valid),
        .i_ready (i_out_ready),
        .o_data  (result)
    );

    assign o_out_first      = result.first;
    assign o_out_second     = result.second;
    assign o_letter_missing = result.missing;

endmodule

[hw/rtl/tsdc_checker.sv]
`timescale 1ns / 1ps

module tsdc_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_in_valid,
    input logic       o_in_ready,
    input logic       o_out_valid,
    input logic       i_out_ready,
    input logic [4:0] o_out_first,
    input logic [4:0] o_out_second,
    input logic       o_letter_missing
);

    // An empty output stage means every stage can take an item.
    a_ready_when_drained: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_out_valid |-> o_in_ready)
        else $error("input not ready while output stage is empty");

    // With the receiver taking results, an accepted item passes the pipeline registers and then shows as valid output.
    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready && i_out_ready) ##1 i_out_ready ##1 i_out_ready
        ##1 i_out_ready |=> o_out_valid)
        else $error("result missing four cycles after acceptance");

    a_valid_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !i_out_ready) |=> o_out_valid)
        else $error("output valid dropped during stall");

    a_payload_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !i_out_ready) |=>
        ($stable(o_out_first) && $stable(o_out_second) && $stable(o_letter_missing)))
        else $error("output item changed during stall");

endmodule

bind two_square_digraph_cipher tsdc_checker u_tsdc_checker (
    .i_clk            (i_clk),
    .i_rst_n          (i_rst_n),
    .i_in_valid       (i_in_valid),
    .o_in_ready       (o_in_ready),
    .o_out_valid      (o_out_valid),
    .i_out_ready      (i_out_ready),
    .o_out_first      (o_out_first),
    .o_out_second     (o_out_second),
    .o_letter_missing (o_letter_missing)
);
